/* rtl/cursor_array_list_top_assert.svh */
// ----------------------------------------------------------------------------
// cursor_array_list_top_assert.svh
// Assertion macros shared by the list checker.
// ----------------------------------------------------------------------------
`ifndef CURSOR_ARRAY_LIST_TOP_ASSERT_SVH
`define CURSOR_ARRAY_LIST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list check failed");

`endif

/* rtl/cal_pkg.sv */
// ----------------------------------------------------------------------------
// cal_pkg
// Types and constants of the cursor list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    localparam int DATA_W  = 32;   // list entry width
    localparam int CMD_W   = 3;
    localparam int ST_W    = 2;
    localparam int ENT_W   = 5;    // count, cursor and capacity fields
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam logic [ENT_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] REMOVE_ERR = '1;   // -1 on failed remove

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_CAPACITY_LIMIT = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_START  = 3'd3,
        CMD_END    = 3'd4,
        CMD_PREV   = 3'd5,
        CMD_NEXT   = 3'd6
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,   // write at pos, cells above pos take left neighbor
        OP_REMOVE = 2'd2    // cells at and above pos take right neighbor
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [DATA_W-1:0]     value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/cal_cell.sv */
// ----------------------------------------------------------------------------
// cal_cell
// One list slot: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire                          clk,
    input  cal_pkg::cell_cmd_t           cell_cmd,
    input  wire  [IW-1:0]                pos,
    input  wire  [cal_pkg::DATA_W-1:0]   left_data,
    input  wire  [cal_pkg::DATA_W-1:0]   right_data,
    output logic [cal_pkg::DATA_W-1:0]   data,
    output logic [cal_pkg::DATA_W-1:0]   rd_data
);
    import cal_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cell_cmd.op)
            OP_INSERT:
            begin
                if (pos == MY_IDX)
                begin
                    data_next = cell_cmd.value;
                end
                else if (pos < MY_IDX)
                begin
                    data_next = left_data;
                end
            end
            OP_REMOVE:
            begin
                if (pos <= MY_IDX)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (pos == MY_IDX) ? data_reg : '0;

endmodule

`default_nettype wire

/* rtl/cal_ctrl.sv */
// ----------------------------------------------------------------------------
// cal_ctrl
// Command decode, count and cursor, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ctrl #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_valid,
    output logic                         cmd_stall,
    input  wire  [cal_pkg::CMD_W-1:0]    cmd,
    input  wire  [cal_pkg::DATA_W-1:0]   item_value,
    input  wire  [cal_pkg::ENT_W-1:0]    capacity,
    input  wire  [cal_pkg::DATA_W-1:0]   rd_data,
    output cal_pkg::cell_cmd_t           cell_cmd,
    output logic [IW-1:0]                pos,
    output logic                         res_valid,
    input  wire                          res_stall,
    output logic [cal_pkg::ST_W-1:0]     status,
    output logic [cal_pkg::DATA_W-1:0]   removed_value,
    output logic [cal_pkg::ENT_W-1:0]    entry_count,
    output logic [cal_pkg::ENT_W-1:0]    cursor_pos
);
    import cal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > ENT_W) ? CW : ENT_W;

    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic              res_valid_reg, res_valid_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] removed_reg, removed_next;
    logic [ENT_W-1:0]  ecount_reg;
    logic [ENT_W-1:0]  cpos_reg;

    logic          accept;
    logic [LW-1:0] limit;
    logic          full;
    cell_op_t      op;

    assign cmd_stall = res_valid_reg & res_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    // limit in force: capacity clamped to the store depth
    assign limit = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
    assign full  = (LW'(count_reg) >= limit);

    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        status_next  = ST_OK;
        removed_next = '0;
        op           = OP_HOLD;
        pos          = IW'(cursor_reg);
        case (cmd_t'(cmd))
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_APPEND:
            begin
                pos = IW'(count_reg);
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (cursor_reg >= count_reg)
                begin
                    status_next  = ST_EMPTY;
                    removed_next = REMOVE_ERR;
                end
                else
                begin
                    op           = OP_REMOVE;
                    removed_next = rd_data;
                    count_next   = count_reg - CW'(1);
                end
            end
            CMD_START:
            begin
                cursor_next = '0;
            end
            CMD_END:
            begin
                cursor_next = count_reg;
            end
            CMD_PREV:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - CW'(1);
                end
            end
            CMD_NEXT:
            begin
                if (cursor_reg < count_reg)
                begin
                    cursor_next = cursor_reg + CW'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        if (!accept)
        begin
            op = OP_HOLD;
        end

        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    assign cell_cmd.op    = op;
    assign cell_cmd.value = item_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            ecount_reg  <= ENT_W'(count_next);
            cpos_reg    <= ENT_W'(cursor_next);
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = ecount_reg;
    assign cursor_pos    = cpos_reg;

endmodule

`default_nettype wire

/* rtl/cursor_array_list_top.sv */
// ----------------------------------------------------------------------------
// cursor_array_list_top
// Ordered list of 32-bit words with a cursor, held in a row of shift cells.
// A result is shown in the cycle after its command is accepted.
// Throughput: one command per cycle unless a result is stalled; insert and
//   remove shift every cell at once; the result register frees when taken.
// Reset: rst_n clears count, cursor and result valid; capacity returns to 16.
//   Entries are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_array_list_top #(
    parameter int DEPTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,

    // command channel
    input  wire                                cmd_valid,
    output logic                               cmd_stall,
    input  wire  [cal_pkg::CMD_W-1:0]          cmd,
    input  wire  signed [cal_pkg::DATA_W-1:0]  item_value,

    // result channel
    output logic                               res_valid,
    input  wire                                res_stall,
    output logic [cal_pkg::ST_W-1:0]           status,
    output logic signed [cal_pkg::DATA_W-1:0]  removed_value,
    output logic [cal_pkg::ENT_W-1:0]          entry_count,
    output logic [cal_pkg::ENT_W-1:0]          cursor_pos,

    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [cal_pkg::ADDR_W-1:0]         paddr,
    input  wire  [cal_pkg::PDATA_W-1:0]        pwdata,
    output logic [cal_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import cal_pkg::*;

    localparam int IW = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Capacity register. Write lands on the access phase of an APB write.
    // Low address bits are don't-care; paddr[2] picks the register.
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] cap_reg;
    logic             cap_hit;
    logic             cap_wr;

    assign pready  = 1'b1;
    assign cap_hit = (paddr[ADDR_W-1:2] == REG_CAPACITY_LIMIT);
    assign cap_wr  = psel & penable & pwrite & pready & cap_hit;
    assign prdata  = cap_hit ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cap_wr)
        begin
            cap_reg <= pwdata[ENT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Controller: decodes the command, keeps count and cursor, and holds
    // the result. It broadcasts one shift op and one slot position to the
    // cell row per accepted item.
    // ------------------------------------------------------------------
    cell_cmd_t         cell_cmd;
    logic [IW-1:0]     pos;
    logic [DATA_W-1:0] rd_any;
    logic [DATA_W-1:0] removed_raw;

    cal_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .item_value    (item_value),
        .capacity      (cap_reg),
        .rd_data       (rd_any),
        .cell_cmd      (cell_cmd),
        .pos           (pos),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .removed_value (removed_raw),
        .entry_count   (entry_count),
        .cursor_pos    (cursor_pos)
    );

    assign removed_value = removed_raw;

    // ------------------------------------------------------------------
    // Cell row. Slot i takes slot i-1 on insert (shift right) and slot
    // i+1 on remove (shift left). Slot 0 has no left neighbor; the last
    // slot recirculates its own word on remove, which is past the count.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cell_cmd.value;
        end
        else
        begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_right
            assign right_w = cell_data[i+1];
        end

        cal_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk        (clk),
            .cell_cmd   (cell_cmd),
            .pos        (pos),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Read of the slot under the cursor: each cell gates its word by the
    // position match, so an OR across the row is the selected entry.
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

endmodule

`default_nettype wire

/* rtl/cal_checker.sv */
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks of the cursor list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_array_list_top_assert.svh"

module cal_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_valid,
    input  wire                          cmd_stall,
    input  wire                          res_valid,
    input  wire                          res_stall,
    input  wire  [cal_pkg::ST_W-1:0]     status,
    input  wire  [cal_pkg::DATA_W-1:0]   removed_value,
    input  wire  [cal_pkg::ENT_W-1:0]    entry_count,
    input  wire  [cal_pkg::ENT_W-1:0]    cursor_pos
);
    import cal_pkg::*;

    // an accepted command shows its result on the next cycle
    `CAL_ASSERT_NXT(a_accept_gives_result, cmd_valid && !cmd_stall, res_valid)

    // cursor never runs past the end of the list
    `CAL_ASSERT_NOW(a_cursor_in_range, res_valid, cursor_pos <= entry_count)

    // a failed remove returns all ones
    `CAL_ASSERT_NOW(a_remove_err_value, res_valid && status == ST_EMPTY,
                    removed_value == REMOVE_ERR)

    // a stalled result holds
    `CAL_ASSERT_NXT(a_result_holds, res_valid && res_stall,
                    res_valid && $stable(status) && $stable(removed_value)
                    && $stable(entry_count) && $stable(cursor_pos))

endmodule

bind cursor_array_list_top cal_checker u_cal_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count),
    .cursor_pos    (cursor_pos)
);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor list engine. A behavioral copy of the
// list (cells, count, cursor, capacity) predicts every result. Directed items
// cover the empty list, edits at the cursor, clamped cursor moves and the
// capacity limit. Random traffic in fill, drain, wander and mixed modes follows,
// across several capacity settings. Sender bursts and receiver stalls are
// random throughout.
// ----------------------------------------------------------------------------

module tb_top;
    import cal_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 140;
    localparam int SETTLE_CYCLES  = 2;    // result shows in the cycle after accept

    // cmd 7 has no meaning; the block must leave the list alone
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // random traffic modes
    localparam int MODE_FILL   = 0;
    localparam int MODE_DRAIN  = 1;
    localparam int MODE_WANDER = 2;
    localparam int MODE_MIXED  = 3;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_SPARSE = 1;
    localparam int STALL_CYCLIC = 2;
    localparam int STALL_HEAVY  = 3;

    typedef struct packed {
        status_t                  status;
        logic [DATA_W-1:0]        removed;
        logic [ENT_W-1:0]         count;
        logic [ENT_W-1:0]         cursor;
    } list_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_stall;
    logic [CMD_W-1:0]           cmd;
    logic signed [DATA_W-1:0]   item_value;
    logic                       res_valid;
    logic                       res_stall;
    logic [ST_W-1:0]            status;
    logic signed [DATA_W-1:0]   removed_value;
    logic [ENT_W-1:0]           entry_count;
    logic [ENT_W-1:0]           cursor_pos;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // behavioral copy of the list
    logic [DATA_W-1:0]  list_cells [LIST_DEPTH];
    int                 list_count;
    int                 list_cursor;
    int                 cap_value;

    list_result_t       awaited_results [$];
    int                 fail_count;
    int                 burst_left;
    int                 quiet_cycles;
    int                 stall_mode;
    int                 stall_mode_left;
    int                 stall_tick;

    cursor_array_list_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .item_value   (item_value),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .removed_value(removed_value),
        .entry_count  (entry_count),
        .cursor_pos   (cursor_pos),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one command to the local list and returns the result
    // the block should report for it.
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] op,
                                                        input logic [DATA_W-1:0] value);
        list_result_t r;
        int           slot;
        int           limit;
        r.status  = ST_OK;
        r.removed = '0;
        // capacity above the store depth acts as the depth
        limit = (cap_value < LIST_DEPTH) ? cap_value : LIST_DEPTH;
        case (op)
            CMD_INSERT, CMD_APPEND:
            begin
                // full also covers a capacity lowered below the current count
                if (list_count >= limit)
                    r.status = ST_FULL;
                else
                begin
                    slot = (op == CMD_INSERT) ? list_cursor : list_count;
                    for (int i = LIST_DEPTH - 1; i > slot; i--)
                        if (i <= list_count)
                            list_cells[i] = list_cells[i - 1];
                    list_cells[slot] = value;
                    list_count++;
                end
            end
            CMD_REMOVE:
            begin
                // cursor at the end: nothing to take, report -1
                if (list_cursor >= list_count)
                begin
                    r.status  = ST_EMPTY;
                    r.removed = REMOVE_ERR;
                end
                else
                begin
                    r.removed = list_cells[list_cursor];
                    for (int i = list_cursor; i < list_count - 1; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_count--;
                end
            end
            CMD_START: list_cursor = 0;
            CMD_END:   list_cursor = list_count;
            CMD_PREV:  if (list_cursor != 0) list_cursor--;
            CMD_NEXT:  if (list_cursor < list_count) list_cursor++;
            default:   ;    // unused code changes nothing
        endcase
        r.count  = ENT_W'(list_count);
        r.cursor = ENT_W'(list_cursor);
        return r;
    endfunction

    // mostly random words, with the extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int mode);
        int roll;
        int add_share;
        int rem_share;
        roll = $urandom_range(0, 99);
        if (roll == 0)
            return CMD_UNUSED;
        case (mode)
            MODE_FILL:   begin add_share = 65; rem_share = 10; end
            MODE_DRAIN:  begin add_share = 15; rem_share = 50; end
            MODE_WANDER: begin add_share = 15; rem_share = 15; end
            default:     begin add_share = 35; rem_share = 25; end
        endcase
        if (roll < add_share)
            return ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_APPEND;
        if (roll < add_share + rem_share)
            return CMD_REMOVE;
        case ($urandom_range(0, 5))
            0:       return CMD_START;
            1:       return CMD_END;
            2, 3:    return CMD_PREV;
            default: return CMD_NEXT;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one item per call, held until accepted. Bursts of random length,
    // each opened by an idle gap; now and then a long burst.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        cmd_valid  <= 1'b1;
        cmd        <= op;
        item_value <= value;
        do @(posedge clk); while (cmd_stall);
        awaited_results.push_back(apply_list_command(op, value));
    endtask

    // stop sending and wait until every result is back
    task automatic wait_until_drained();
        cmd_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // capacity write, then read back; only called with the block idle
    task automatic write_capacity(input logic [ENT_W-1:0] value);
        logic [PDATA_W-1:0] word;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        word = $urandom;
        word[ENT_W-1:0] = value;    // upper bits are don't-care
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY_LIMIT, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cap_value = int'(value);
        // back-to-back read of the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(value))
        begin
            $display("%0t: capacity_limit readback expected %h actual %h",
                     $time, PDATA_W'(value), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        list_result_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual status %h count %h",
                     $time, status, entry_count);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(status));
            check_field("removed_value", want.removed, removed_value);
            check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
            check_field("cursor_pos", DATA_W'(want.cursor), DATA_W'(cursor_pos));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_result();
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_mode_left = $urandom_range(20, 120);
        end
        stall_mode_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:   res_stall <= 1'b0;
            STALL_SPARSE: res_stall <= ($urandom_range(0, 3) == 0);
            STALL_CYCLIC: res_stall <= (stall_tick % 3 != 0);
            default:      res_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog: too long with nothing moving on any port
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // fresh list: remove fails, moves clamp at 0, unused code is a no-op
    task automatic test_empty_list();
        send_item(CMD_REMOVE, pick_value());
        send_item(CMD_PREV, pick_value());
        send_item(CMD_NEXT, pick_value());
        send_item(CMD_END, pick_value());
        send_item(CMD_UNUSED, pick_value());
        send_item(CMD_START, pick_value());
    endtask

    // inserts and removes at the cursor, remove at end, next clamped at count
    task automatic test_edits_at_cursor();
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_APPEND, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF);
        send_item(CMD_NEXT, '0);
        send_item(CMD_INSERT, 32'h5555_5555);
        send_item(CMD_END, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_PREV, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_START, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '0);
    endtask

    // capacity below count, zero capacity, capacity above the store depth
    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_item(CMD_APPEND, 32'h0000_0001);
        send_item(CMD_INSERT, 32'h0000_0002);
        send_item(CMD_START, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_APPEND, 32'h0000_0003);
        write_capacity(5'd0);
        send_item(CMD_INSERT, 32'h0000_0004);
        write_capacity(5'd31);
        send_item(CMD_APPEND, 32'hAAAA_AAAA);
    endtask

    // random traffic over a sweep of capacities
    task automatic test_random_traffic();
        logic [ENT_W-1:0] caps [12];
        int               mode;
        int               mode_left;
        caps = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd17, 5'd8, 5'd16, 5'd3, 5'd15,
                 5'd16, 5'd16};
        caps[10] = ENT_W'($urandom_range(0, 31));
        mode_left = 0;
        mode = MODE_MIXED;
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(MODE_FILL, MODE_MIXED);
                    mode_left = $urandom_range(4, 40);
                end
                mode_left--;
                // hold off now and then until everything has come back
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0)
                    wait_until_drained();
                send_item(pick_command(mode), pick_value());
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        cmd        <= CMD_START;
        item_value <= '0;
        res_stall  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        fail_count      = 0;
        burst_left      = 0;
        quiet_cycles    = 0;
        stall_mode      = STALL_NONE;
        stall_mode_left = 0;
        stall_tick      = 0;
        list_count      = 0;
        list_cursor     = 0;
        cap_value       = int'(CAP_RESET);
        foreach (list_cells[i])
            list_cells[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edits_at_cursor();
        test_capacity_limits();
        test_random_traffic();

        wait_until_drained();
        repeat (SETTLE_CYCLES + 2) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
